// ===== sv/aec_pkg.sv =====
package aec_pkg;

  // default sizing
  localparam int NUM_SYMBOLS_DEF = 16;
  localparam int PRECISION_DEF   = 16;
  localparam int MAX_RUN_DEF     = 65535;

  // fixed field widths
  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 5;
  localparam int TVAL_W   = 17;
  localparam int SYM_W    = 4;
  localparam int RUN_W    = 16;
  localparam int TDATA_IN_W  = 32;
  localparam int TDATA_OUT_W = 24;

  // table value equal to one
  localparam logic [TVAL_W-1:0] TABLE_ONE = 17'h10000;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FLUSH  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MLO, S_MHI, S_UPD, S_RENORM, S_FA, S_FB, S_REL, S_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_START, OP_MLO, OP_MHI, OP_UPD, OP_RENORM,
    OP_FA, OP_FB, OP_REL, OP_FIN
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic can_emit;        // output register free this cycle
    logic len_small;       // length below one half
    logic base_over_half;  // base above one half
    logic idx_ok;          // load index within table
    logic sym_ok;          // symbol within alphabet
    logic hold_valid;      // a result waits in the hold register
  } status_t;

endpackage

// ===== sv/aec_ram.sv =====
module aec_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/aec_ctrl.sv =====
module aec_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  aec_pkg::action_t         action,
  input  aec_pkg::status_t         status,
  output logic                     in_ready,
  output aec_pkg::cmd_t            cmd
);

  aec_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aec_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      aec_pkg::S_IDLE: begin
        if (in_valid) begin
          if (action == aec_pkg::ACT_ENCODE && status.sym_ok) begin
            state_next = aec_pkg::S_MLO;
          end else if (action == aec_pkg::ACT_FLUSH) begin
            state_next = aec_pkg::S_FA;
          end
        end
      end
      aec_pkg::S_MLO: state_next = aec_pkg::S_MHI;
      aec_pkg::S_MHI: state_next = aec_pkg::S_UPD;
      aec_pkg::S_UPD: begin
        if (status.can_emit) state_next = aec_pkg::S_RENORM;
      end
      aec_pkg::S_RENORM: begin
        if (!status.len_small) state_next = aec_pkg::S_FIN;
      end
      aec_pkg::S_FA: begin
        if (status.can_emit) begin
          state_next = status.base_over_half ? aec_pkg::S_FB : aec_pkg::S_REL;
        end
      end
      aec_pkg::S_FB: begin
        if (status.can_emit) state_next = aec_pkg::S_REL;
      end
      aec_pkg::S_REL: begin
        if (status.can_emit) state_next = aec_pkg::S_FIN;
      end
      aec_pkg::S_FIN: begin
        if (!status.hold_valid || status.can_emit) state_next = aec_pkg::S_IDLE;
      end
      default: state_next = aec_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd.op   = aec_pkg::OP_NONE;
    in_ready = 1'b0;
    case (state)
      aec_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (action == aec_pkg::ACT_LOAD && status.idx_ok) begin
            cmd.op = aec_pkg::OP_LOAD;
          end else if (action == aec_pkg::ACT_ENCODE && status.sym_ok) begin
            cmd.op = aec_pkg::OP_START;
          end
        end
      end
      aec_pkg::S_MLO: cmd.op = aec_pkg::OP_MLO;
      aec_pkg::S_MHI: cmd.op = aec_pkg::OP_MHI;
      aec_pkg::S_UPD: begin
        if (status.can_emit) cmd.op = aec_pkg::OP_UPD;
      end
      aec_pkg::S_RENORM: begin
        if (status.len_small && status.can_emit) cmd.op = aec_pkg::OP_RENORM;
      end
      aec_pkg::S_FA: begin
        if (status.can_emit) cmd.op = aec_pkg::OP_FA;
      end
      aec_pkg::S_FB: begin
        if (status.can_emit) cmd.op = aec_pkg::OP_FB;
      end
      aec_pkg::S_REL: begin
        if (status.can_emit) cmd.op = aec_pkg::OP_REL;
      end
      aec_pkg::S_FIN: begin
        if (status.hold_valid && status.can_emit) cmd.op = aec_pkg::OP_FIN;
      end
      default: cmd.op = aec_pkg::OP_NONE;
    endcase
  end

endmodule

// ===== sv/aec_datapath.sv =====
module aec_datapath #(
  parameter int NUM_SYMBOLS = aec_pkg::NUM_SYMBOLS_DEF,
  parameter int PRECISION   = aec_pkg::PRECISION_DEF,
  parameter int MAX_RUN     = aec_pkg::MAX_RUN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  aec_pkg::cmd_t                 cmd,
  input  logic [aec_pkg::INDEX_W-1:0]   table_index,
  input  logic [aec_pkg::TVAL_W-1:0]    table_value,
  input  logic [aec_pkg::SYM_W-1:0]     symbol,
  output aec_pkg::status_t              status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          lead_bit,
  output logic                          run_bit,
  output logic [aec_pkg::RUN_W-1:0]     run_count,
  output logic                          overflow_error,
  output logic                          last
);

  localparam int P   = PRECISION;
  localparam int LW  = P + 1;
  localparam int AW  = $clog2(NUM_SYMBOLS + 1);
  localparam int PW  = LW + aec_pkg::TVAL_W;
  localparam logic [LW-1:0] ONE  = LW'(1) << P;
  localparam logic [LW-1:0] HALF = LW'(1) << (P - 1);
  localparam int LEN_MIN_I = (P > 17) ? (1 << (P - 17)) : 1;
  localparam logic [LW-1:0] LEN_MIN = LW'(LEN_MIN_I);
  localparam logic [aec_pkg::RUN_W-1:0] RUN_MAX = aec_pkg::RUN_W'(MAX_RUN);

  // interval and held bits
  logic [P-1:0]              base_q;
  logic [LW-1:0]             len_q;
  logic [LW-1:0]             p_lo, p_hi;
  logic [aec_pkg::SYM_W-1:0] sym_q;
  logic                      pz;
  logic [aec_pkg::RUN_W-1:0] run;

  // hold register: newest result, marked last when the word ends
  logic                      hold_v;
  logic                      h_lead, h_rbit, h_err;
  logic [aec_pkg::RUN_W-1:0] h_cnt;

  // table memory
  logic [AW-1:0]              raddr, waddr;
  logic [aec_pkg::TVAL_W-1:0] rdata, t_cl;
  logic                       we;

  assign we    = (cmd.op == aec_pkg::OP_LOAD);
  assign waddr = AW'(32'(table_index));
  assign raddr = (cmd.op == aec_pkg::OP_MLO) ? AW'(32'(sym_q) + 32'd1) : AW'(32'(symbol));

  aec_ram #(.WIDTH(aec_pkg::TVAL_W), .DEPTH(NUM_SYMBOLS + 1)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (table_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // clamp and scale; one shared multiplier
  logic [PW-1:0] prod;
  logic [LW-1:0] frac;
  assign t_cl = (rdata > aec_pkg::TABLE_ONE) ? aec_pkg::TABLE_ONE : rdata;
  assign prod = PW'(len_q) * PW'(t_cl);
  assign frac = prod[LW+15:16];

  // slice ends from the old base
  logic [LW-1:0] lo, hi, diff, len_upd;
  assign lo   = LW'(base_q) + p_lo;
  assign hi   = LW'(base_q) + p_hi;
  assign diff = (hi > lo) ? (hi - lo) : '0;
  assign len_upd = (diff < LEN_MIN) ? LEN_MIN : diff;

  // bit release logic
  logic                      do_put, put_val, do_carry, do_rel;
  logic                      e_v, e_lead, e_rbit, e_err;
  logic [aec_pkg::RUN_W-1:0] e_cnt;
  logic                      pz_next;
  logic [aec_pkg::RUN_W-1:0] run_next;

  always_comb begin
    do_put   = 1'b0;
    put_val  = 1'b0;
    do_carry = 1'b0;
    do_rel   = 1'b0;
    case (cmd.op)
      aec_pkg::OP_UPD:    do_carry = lo[P];
      aec_pkg::OP_RENORM: begin
        do_put  = 1'b1;
        put_val = base_q[P-1];
      end
      aec_pkg::OP_FA: begin
        if (status.base_over_half) begin
          do_carry = 1'b1;
        end else begin
          do_put  = 1'b1;
          put_val = 1'b1;
        end
      end
      aec_pkg::OP_FB:  do_put = 1'b1;
      aec_pkg::OP_REL: do_rel = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    e_v      = 1'b0;
    e_lead   = 1'b0;
    e_rbit   = 1'b0;
    e_cnt    = '0;
    e_err    = 1'b0;
    pz_next  = pz;
    run_next = run;
    if (do_carry) begin
      if (!pz) begin
        e_v   = 1'b1;
        e_err = 1'b1;
      end else if (run == '0) begin
        pz_next  = 1'b0;
        run_next = aec_pkg::RUN_W'(1);
      end else begin
        e_v      = 1'b1;
        e_lead   = 1'b1;
        e_cnt    = run - 1'b1;
        pz_next  = 1'b1;
        run_next = '0;
      end
    end else if (do_put || do_rel) begin
      // release the held group when a zero, saturation or flush asks for it
      if (do_rel || (!put_val && (pz || run != '0)) || (put_val && run >= RUN_MAX)) begin
        e_v    = pz || (run != '0);
        e_lead = !pz;
        e_rbit = 1'b1;
        e_cnt  = pz ? run : run - 1'b1;
        e_err  = do_put && put_val;
      end
      if (do_rel) begin
        pz_next  = 1'b0;
        run_next = '0;
      end else if (!put_val) begin
        pz_next  = 1'b1;
        run_next = '0;
      end else if (run >= RUN_MAX) begin
        pz_next  = 1'b0;
        run_next = aec_pkg::RUN_W'(1);
      end else begin
        run_next = run + 1'b1;
      end
    end
  end

  // interval registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_q <= '0;
      len_q  <= ONE;
      pz     <= 1'b0;
      run    <= '0;
    end else begin
      pz  <= pz_next;
      run <= run_next;
      case (cmd.op)
        aec_pkg::OP_UPD: begin
          base_q <= lo[P-1:0];
          len_q  <= len_upd;
        end
        aec_pkg::OP_RENORM: begin
          base_q <= {base_q[P-2:0], 1'b0};
          len_q  <= {len_q[LW-2:0], 1'b0};
        end
        aec_pkg::OP_REL: begin
          base_q <= '0;
          len_q  <= ONE;
        end
        default: ;
      endcase
    end
  end

  // symbol and scaled slice ends
  always_ff @(posedge clk) begin
    if (cmd.op == aec_pkg::OP_START) sym_q <= symbol;
    if (cmd.op == aec_pkg::OP_MLO)   p_lo  <= frac;
    if (cmd.op == aec_pkg::OP_MHI)   p_hi  <= frac;
  end

  // hold and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (e_v) begin
        hold_v <= 1'b1;
      end else if (cmd.op == aec_pkg::OP_FIN) begin
        hold_v <= 1'b0;
      end
      // output loads from the hold register, empties once taken
      if ((e_v && hold_v) || cmd.op == aec_pkg::OP_FIN) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e_v) begin
      h_lead <= e_lead;
      h_rbit <= e_rbit;
      h_cnt  <= e_cnt;
      h_err  <= e_err;
    end
    if ((e_v && hold_v) || cmd.op == aec_pkg::OP_FIN) begin
      lead_bit       <= h_lead;
      run_bit        <= h_rbit;
      run_count      <= h_cnt;
      overflow_error <= h_err;
      last           <= (cmd.op == aec_pkg::OP_FIN);
    end
  end

  // status to controller
  assign status.can_emit       = !out_valid || out_ready;
  assign status.len_small      = (len_q < HALF);
  assign status.base_over_half = (LW'(base_q) > HALF);
  assign status.idx_ok         = (32'(table_index) <= 32'(NUM_SYMBOLS));
  assign status.sym_ok         = (32'(symbol) < 32'(NUM_SYMBOLS));
  assign status.hold_valid     = hold_v;

endmodule

// ===== sv/arithmetic_encoder_carry.sv =====
// Static-table binary arithmetic encoder with carry resolution.
// Input channel s_*: one word per action. s_tuser holds the action
// (load table entry, encode symbol, flush). Loads write one entry of the
// cumulative table in the accepting cycle.
// Output channel m_*: groups of code bits, a lead bit followed by
// run_count copies of run_bit; m_tuser flags a dropped carry or a
// saturated run; m_tlast marks the final group caused by an input word.
// Steps: an encode makes two table reads through the one memory port,
// sharing one multiplier, then the interval update, then one step per
// renormalising doubling, one step to leave renormalisation and one to
// release the final group. A flush takes a carry or bit step, a second
// bit step when the base is above one half, then release and final. Each step
// releases at most one group, so a stalled receiver holds the sequencer
// in that step; one group waits in the output register while the next
// is formed. Words are accepted one at a time.
// Reset clears the interval and held bits and empties the output; the
// table contents are undefined until loaded and survive flushes.
module arithmetic_encoder_carry #(
  parameter int NUM_SYMBOLS = aec_pkg::NUM_SYMBOLS_DEF,
  parameter int PRECISION   = aec_pkg::PRECISION_DEF,
  parameter int MAX_RUN     = aec_pkg::MAX_RUN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // table_index[4:0], table_value[21:5], symbol[25:22]
  input  logic [1:0]  s_tuser,  // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // lead_bit[0], run_bit[1], run_count[17:2]
  output logic        m_tuser,  // overflow_error[0]
  output logic        m_tlast
);

  aec_pkg::cmd_t    cmd;
  aec_pkg::status_t status;
  logic             lead_bit, run_bit;
  logic [15:0]      run_count;

  aec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .action   (aec_pkg::action_t'(s_tuser)),
    .status   (status),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  aec_datapath #(
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .PRECISION   (PRECISION),
    .MAX_RUN     (MAX_RUN)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .table_index    (s_tdata[4:0]),
    .table_value    (s_tdata[21:5]),
    .symbol         (s_tdata[25:22]),
    .status         (status),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .lead_bit       (lead_bit),
    .run_bit        (run_bit),
    .run_count      (run_count),
    .overflow_error (m_tuser),
    .last           (m_tlast)
  );

  assign m_tdata = {6'd0, run_count, run_bit, lead_bit};

endmodule

// ===== sv/aec_checker.sv =====
module aec_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // output register empties on reset
  assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

  // a dropped carry carries no code bits
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser && !m_tdata[1]) |-> (m_tdata[17:0] == 18'd0))
    else $error("carry error word holds code bits");

  // stalled word holds
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output changed");

  // pad bits stay clear
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[23:18] == 6'd0))
    else $error("pad bits set");

endmodule

bind arithmetic_encoder_carry aec_checker u_aec_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
